[hdl/msb_pkg.sv]
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants for the multidrop serial bridge.
// ----------------------------------------------------------------------------
package msb_pkg;

  // Byte counts hold up to the largest supported buffer depth (63)
  localparam int CNT_W = 6;

  // Request commands
  localparam logic [1:0] CMD_HOST = 2'd0;
  localparam logic [1:0] CMD_DEV  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Result destinations
  localparam logic [1:0] DEST_DEV    = 2'd0;
  localparam logic [1:0] DEST_HOST   = 2'd1;
  localparam logic [1:0] DEST_STATUS = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_DEVICE_ID  = 2'd0;
  localparam logic [1:0] REG_END_MARKER = 2'd1;
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd2;
  localparam logic [1:0] REG_LAMP_HOLD  = 2'd3;

  localparam int          PADDR_W      = 4;
  localparam logic [3:0]  RST_DEVICE_ID  = 4'd0;
  localparam logic [7:0]  RST_END_MARKER = 8'd88;
  localparam logic [7:0]  RST_IDLE_LIMIT = 8'd30;
  localparam logic [15:0] RST_LAMP_HOLD  = 16'd2000;

  typedef struct packed {
    logic [3:0]  device_id;
    logic [7:0]  end_marker;
    logic [7:0]  idle_limit;
    logic [15:0] lamp_hold;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // request taken this cycle
    logic fetch;     // pick next result: header or buffer read
    logic load_ram;  // buffer read data is valid, load output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run_start;   // the request on the input starts a result run
    logic hdr_pending; // next result comes without a buffer read
    logic last;        // output register holds the final result of the run
  } dp_stat_t;

endpackage

[hdl/msb_ifs.sv]
// ----------------------------------------------------------------------------
// msb_ifs
// Request and result channel interfaces of the multidrop serial bridge.
// ----------------------------------------------------------------------------
interface msb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_in;

  modport source (output valid, command, data_in, input ready);
  modport sink   (input valid, command, data_in, output ready);
endinterface

interface msb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] dest;
  logic [7:0] data_out;
  logic       last;
  logic       lamp_rx;
  logic       lamp_tx;

  modport source (output valid, dest, data_out, last, lamp_rx, lamp_tx, input ready);
  modport sink   (input valid, dest, data_out, last, lamp_rx, lamp_tx, output ready);
endinterface

[hdl/msb_ram.sv]
// ----------------------------------------------------------------------------
// msb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/msb_regs.sv]
// ----------------------------------------------------------------------------
// msb_regs
// APB configuration registers: device id, end marker, idle limit, lamp hold.
// ----------------------------------------------------------------------------
module msb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output msb_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_id  <= msb_pkg::RST_DEVICE_ID;
      cfg.end_marker <= msb_pkg::RST_END_MARKER;
      cfg.idle_limit <= msb_pkg::RST_IDLE_LIMIT;
      cfg.lamp_hold  <= msb_pkg::RST_LAMP_HOLD;
    end else if (wr_en) begin
      case (reg_idx)
        msb_pkg::REG_DEVICE_ID:  cfg.device_id  <= pwdata[3:0];
        msb_pkg::REG_END_MARKER: cfg.end_marker <= pwdata[7:0];
        msb_pkg::REG_IDLE_LIMIT: cfg.idle_limit <= pwdata[7:0];
        msb_pkg::REG_LAMP_HOLD:  cfg.lamp_hold  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      msb_pkg::REG_DEVICE_ID:  prdata = {28'd0, cfg.device_id};
      msb_pkg::REG_END_MARKER: prdata = {24'd0, cfg.end_marker};
      msb_pkg::REG_IDLE_LIMIT: prdata = {24'd0, cfg.idle_limit};
      msb_pkg::REG_LAMP_HOLD:  prdata = {16'd0, cfg.lamp_hold};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

[hdl/msb_ctrl.sv]
// ----------------------------------------------------------------------------
// msb_ctrl
// Sequencer: takes requests, then walks a result run one result at a time.
// ----------------------------------------------------------------------------
module msb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  msb_pkg::dp_stat_t     stat,
  output msb_pkg::ctrl_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_SEND  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_SEND);
  assign cmd.accept   = in_ready & in_valid;
  assign cmd.fetch    = (state == S_FETCH);
  assign cmd.load_ram = (state == S_READ);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept && stat.run_start) state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = stat.hdr_pending ? S_SEND : S_READ;
      end
      S_READ: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_ready) state_next = stat.last ? S_IDLE : S_FETCH;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/msb_dp.sv]
// ----------------------------------------------------------------------------
// msb_dp
// Datapath: frame buffers, counters, lamp timers and the result register.
// ----------------------------------------------------------------------------
module msb_dp #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  msb_pkg::cfg_t       cfg,
  input  msb_pkg::ctrl_cmd_t  cmd,
  output msb_pkg::dp_stat_t   stat,
  input  logic [1:0]          command,
  input  logic [7:0]          data_in,
  output logic [1:0]          dest,
  output logic [7:0]          data_out,
  output logic                last,
  output logic                lamp_rx,
  output logic                lamp_tx
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [msb_pkg::CNT_W-1:0] DEPTH_C = msb_pkg::CNT_W'(PAYLOAD_DEPTH);

  logic                      host_in_frame;
  logic [msb_pkg::CNT_W-1:0] host_count;
  logic [msb_pkg::CNT_W-1:0] dev_count;
  logic [7:0]                idle_ticks;
  logic [15:0]               rx_lamp_timer;
  logic [15:0]               tx_lamp_timer;

  // Run registers
  logic                      run_dev;
  logic                      hdr_pending;
  logic [1:0]                run_dest;
  logic [7:0]                hdr_byte;
  logic [msb_pkg::CNT_W-1:0] run_left;
  logic [msb_pkg::CNT_W-1:0] run_pos;

  logic                      is_host;
  logic                      is_dev;
  logic                      is_tick;
  logic                      id_match;
  logic                      host_room;
  logic                      dev_room;
  logic                      host_we;
  logic                      dev_we;
  logic                      frame_end;
  logic [msb_pkg::CNT_W-1:0] host_count_next;
  logic [8:0]                idle_next;
  logic                      flush;
  logic [7:0]                host_rdata;
  logic [7:0]                dev_rdata;

  assign is_host   = (command == msb_pkg::CMD_HOST);
  assign is_dev    = (command == msb_pkg::CMD_DEV);
  assign is_tick   = (command == msb_pkg::CMD_TICK);
  assign id_match  = (data_in == {4'd0, cfg.device_id});
  assign host_room = (host_count < DEPTH_C);
  assign dev_room  = (dev_count < DEPTH_C);
  assign host_we   = cmd.accept & is_host & host_in_frame & host_room;
  assign dev_we    = cmd.accept & is_dev & dev_room;
  assign frame_end = is_host & host_in_frame & (data_in == cfg.end_marker);
  assign host_count_next = host_room ? host_count + 1'b1 : host_count;
  assign idle_next = {1'b0, idle_ticks} + 9'd1;
  assign flush     = (dev_count != '0) & (idle_next > {1'b0, cfg.idle_limit});

  assign stat.run_start   = is_tick | (frame_end & (host_count_next != '0));
  assign stat.hdr_pending = hdr_pending;
  assign stat.last        = last;

  msb_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_host_ram (
    .clk   (clk),
    .we    (host_we),
    .waddr (host_count[AW-1:0]),
    .wdata (data_in),
    .re    (cmd.fetch),
    .raddr (run_pos[AW-1:0]),
    .rdata (host_rdata)
  );

  msb_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_dev_ram (
    .clk   (clk),
    .we    (dev_we),
    .waddr (dev_count[AW-1:0]),
    .wdata (data_in),
    .re    (cmd.fetch),
    .raddr (run_pos[AW-1:0]),
    .rdata (dev_rdata)
  );

  // Link state, counters and lamp timers
  always_ff @(posedge clk) begin
    if (rst) begin
      host_in_frame <= 1'b0;
      host_count    <= '0;
      dev_count     <= '0;
      idle_ticks    <= '0;
      rx_lamp_timer <= '0;
      tx_lamp_timer <= '0;
      lamp_rx       <= 1'b0;
      lamp_tx       <= 1'b0;
    end else if (cmd.accept) begin
      if (is_host) begin
        if (!host_in_frame) begin
          if (id_match) begin
            host_in_frame <= 1'b1;
            host_count    <= '0;
          end
        end else if (frame_end) begin
          host_in_frame <= 1'b0;
          host_count    <= '0;
          rx_lamp_timer <= cfg.lamp_hold;
        end else begin
          host_count <= host_count_next;
        end
      end else if (is_dev) begin
        if (dev_room) dev_count <= dev_count + 1'b1;
        idle_ticks <= '0;
      end else if (is_tick) begin
        lamp_rx <= (rx_lamp_timer != '0);
        lamp_tx <= (tx_lamp_timer != '0);
        if (rx_lamp_timer != '0) rx_lamp_timer <= rx_lamp_timer - 1'b1;
        if (flush) begin
          tx_lamp_timer <= cfg.lamp_hold;
          dev_count     <= '0;
          idle_ticks    <= '0;
        end else begin
          if (tx_lamp_timer != '0) tx_lamp_timer <= tx_lamp_timer - 1'b1;
          if (dev_count != '0) idle_ticks <= idle_next[7:0];
        end
      end
    end
  end

  // Run setup and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pending <= 1'b0;
      run_left    <= '0;
      run_pos     <= '0;
      run_dev     <= 1'b0;
      run_dest    <= msb_pkg::DEST_STATUS;
      hdr_byte    <= '0;
      last        <= 1'b0;
    end else if (cmd.accept) begin
      run_pos <= '0;
      if (is_tick) begin
        run_dev     <= 1'b1;
        hdr_pending <= 1'b1;
        run_dest    <= flush ? msb_pkg::DEST_HOST : msb_pkg::DEST_STATUS;
        hdr_byte    <= flush ? {4'd0, cfg.device_id} : 8'd0;
        run_left    <= flush ? dev_count : '0;
      end else begin
        run_dev     <= 1'b0;
        hdr_pending <= 1'b0;
        run_dest    <= msb_pkg::DEST_DEV;
        run_left    <= host_count_next;
      end
    end else if (cmd.fetch && hdr_pending) begin
      hdr_pending <= 1'b0;
      dest        <= run_dest;
      data_out    <= hdr_byte;
      last        <= (run_left == '0);
    end else if (cmd.load_ram) begin
      dest     <= run_dest;
      data_out <= run_dev ? dev_rdata : host_rdata;
      last     <= (run_left == 6'd1);
      run_left <= run_left - 1'b1;
      run_pos  <= run_pos + 1'b1;
    end
  end

endmodule

[hdl/multidrop_serial_bridge_top.sv]
// ----------------------------------------------------------------------------
// multidrop_serial_bridge_top
// Bridge between a multidrop host link and a device link.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch: command 0 is a host link byte, 1 a device link
// byte, 2 a one millisecond tick. Results leave on out_ch with a destination,
// a byte, the two lamp latches and last on the final result of a run.
// in_ch is ready only while no run is out. A header or status result passes
// select and the output register; a buffered byte passes select, the buffer
// RAM read and the output register. A tick gives one status result or a
// flush of up to PAYLOAD_DEPTH+1 bytes; an end marker gives the buffered
// host frame. Device and host bytes without a frame end give no result and
// the next request is taken in the following cycle. A stall on out_ch holds
// the result and the sequencer in place. Reset clears counters, timers,
// lamps and registers to their defaults, but for the result byte and its
// destination; the frame buffers need no clearing, as only written entries
// are ever read. Registers are to be written over the APB port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multidrop_serial_bridge_top #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  msb_in_if.sink                      in_ch,
  msb_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  msb_pkg::cfg_t      cfg;
  msb_pkg::ctrl_cmd_t cmd;
  msb_pkg::dp_stat_t  stat;

  msb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  msb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msb_dp #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .command  (in_ch.command),
    .data_in  (in_ch.data_in),
    .dest     (out_ch.dest),
    .data_out (out_ch.data_out),
    .last     (out_ch.last),
    .lamp_rx  (out_ch.lamp_rx),
    .lamp_tx  (out_ch.lamp_tx)
  );

endmodule
